>>> design/srcf_pkg.sv
// ----------------------------------------------------------------------------
// srcf_pkg
// Shared types, constants and helpers for the sensor ring cluster finder.
// ----------------------------------------------------------------------------
package srcf_pkg;

  localparam int SENSOR_COUNT = 48;
  localparam int BITS_W       = 48;
  localparam int MASK_W       = (SENSOR_COUNT > BITS_W) ? SENSOR_COUNT : BITS_W;
  localparam int IDX_W        = 6;
  localparam int CNT_W        = 2;
  localparam int MAX_RUNS     = 3;
  localparam int RUN_SLOTS    = MAX_RUNS + 1;
  localparam int SLOT_W       = $clog2(RUN_SLOTS);
  localparam int RUNS_W       = $clog2(RUN_SLOTS + 2);

  typedef logic [SENSOR_COUNT-1:0] ring_t;
  typedef logic [IDX_W-1:0]        idx_t;

  localparam idx_t SLOT_UNUSED = idx_t'(63);

  // One scan in flight: remaining start/end marks and positions taken so far.
  typedef struct packed {
    ring_t                     rise;
    ring_t                     fall;
    logic                      wrap;
    logic [RUNS_W-1:0]         runs;
    idx_t [RUN_SLOTS-1:0]      starts;
    idx_t [RUN_SLOTS-1:0]      ends;
  } track_t;

  typedef struct packed {
    logic [CNT_W-1:0]     count;
    idx_t [MAX_RUNS-1:0]  cstart;
    idx_t [MAX_RUNS-1:0]  cend;
    logic                 used;
  } res_t;

  function automatic idx_t first_set(ring_t m);
    idx_t pos;
    pos = '0;
    for (int i = SENSOR_COUNT - 1; i >= 0; i--) begin
      if (m[i]) begin
        pos = IDX_W'(i);
      end
    end
    return pos;
  endfunction

endpackage

>>> design/srcf_prep.sv
// ----------------------------------------------------------------------------
// srcf_prep
// Builds the fill-in frame and the start/end marks of both frames.
// ----------------------------------------------------------------------------
module srcf_prep (
  input  srcf_pkg::ring_t  ring,
  output srcf_pkg::track_t orig,
  output srcf_pkg::track_t filled
);

  srcf_pkg::ring_t left;
  srcf_pkg::ring_t right;
  srcf_pkg::ring_t fbits;

  assign left  = {ring[srcf_pkg::SENSOR_COUNT-2:0], ring[srcf_pkg::SENSOR_COUNT-1]};
  assign right = {ring[0], ring[srcf_pkg::SENSOR_COUNT-1:1]};
  assign fbits = ring | (left & right);

  function automatic srcf_pkg::track_t marks(srcf_pkg::ring_t b);
    srcf_pkg::track_t t;
    t        = '0;
    t.rise   = b & ~(b << 1);
    t.fall   = b & ~(b >> 1);
    t.wrap   = b[0] & b[srcf_pkg::SENSOR_COUNT-1];
    t.starts = {srcf_pkg::RUN_SLOTS{srcf_pkg::SLOT_UNUSED}};
    t.ends   = {srcf_pkg::RUN_SLOTS{srcf_pkg::SLOT_UNUSED}};
    return t;
  endfunction

  assign orig   = marks(ring);
  assign filled = marks(fbits);

endmodule

>>> design/srcf_extract.sv
// ----------------------------------------------------------------------------
// srcf_extract
// One step of the run walk: takes the lowest start and end mark into a slot.
// ----------------------------------------------------------------------------
module srcf_extract (
  input  logic [srcf_pkg::SLOT_W-1:0] slot,
  input  srcf_pkg::track_t            din,
  output srcf_pkg::track_t            dout
);

  logic has;

  assign has = |din.rise;

  always_comb begin
    dout = din;
    if (has) begin
      dout.starts[slot] = srcf_pkg::first_set(din.rise);
      dout.ends[slot]   = srcf_pkg::first_set(din.fall);
      dout.rise         = din.rise & (din.rise - srcf_pkg::ring_t'(1));
      dout.fall         = din.fall & (din.fall - srcf_pkg::ring_t'(1));
      dout.runs         = din.runs + srcf_pkg::RUNS_W'(1);
    end
  end

endmodule

>>> design/srcf_assemble.sv
// ----------------------------------------------------------------------------
// srcf_assemble
// Applies the wrap merge, picks first or fill-in scan, fills unused slots.
// ----------------------------------------------------------------------------
module srcf_assemble (
  input  srcf_pkg::track_t orig,
  input  srcf_pkg::track_t filled,
  output srcf_pkg::res_t   res
);

  function automatic srcf_pkg::res_t pack_scan(srcf_pkg::track_t t, output logic fail);
    srcf_pkg::res_t             r;
    logic [srcf_pkg::RUNS_W-1:0] total;
    logic [srcf_pkg::RUNS_W-1:0] cnt;
    r     = '0;
    total = t.runs + srcf_pkg::RUNS_W'(|t.rise);
    cnt   = total - srcf_pkg::RUNS_W'(t.wrap);
    fail  = (cnt > srcf_pkg::RUNS_W'(srcf_pkg::MAX_RUNS));
    r.count = cnt[srcf_pkg::CNT_W-1:0];
    for (int k = 0; k < srcf_pkg::MAX_RUNS; k++) begin
      if (srcf_pkg::RUNS_W'(k) < cnt) begin
        r.cstart[k] = t.starts[k];
        r.cend[k]   = t.ends[k];
      end else begin
        r.cstart[k] = srcf_pkg::SLOT_UNUSED;
        r.cend[k]   = srcf_pkg::SLOT_UNUSED;
      end
    end
    // wrap merge: cluster 0 starts where the last run starts
    if (t.wrap && cnt != '0) begin
      r.cstart[0] = t.starts[cnt[srcf_pkg::SLOT_W-1:0]];
    end
    return r;
  endfunction

  srcf_pkg::res_t r_orig;
  srcf_pkg::res_t r_fill;
  logic           fail_orig;
  logic           fail_fill;

  always_comb begin
    r_orig = pack_scan(orig, fail_orig);
    r_fill = pack_scan(filled, fail_fill);
    if (!fail_orig) begin
      res = r_orig;
    end else if (!fail_fill) begin
      res      = r_fill;
      res.used = 1'b1;
    end else begin
      res        = '0;
      res.cstart = {srcf_pkg::MAX_RUNS{srcf_pkg::SLOT_UNUSED}};
      res.cend   = {srcf_pkg::MAX_RUNS{srcf_pkg::SLOT_UNUSED}};
      res.used   = 1'b1;
    end
  end

endmodule

>>> design/sensor_ring_cluster_finder_unit.sv
// ----------------------------------------------------------------------------
// sensor_ring_cluster_finder_unit
// Finds up to three runs of lit sensors on a ring, with wrap merge and a
// fill-in retry scan.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+------------------------------
//   in      | input     | in_valid / in_ready | sensor_bits
//   out     | output    | out_valid/out_ready | cluster_count, *_start, *_end,
//           |           |                     | used_fill_in
//
// Seven register stages: input, mark build, four run-walk steps (one
// priority encode per step), result. One beat per cycle while out_ready
// holds high. Both scans walk side by side, so the fill-in retry
// does not lengthen the pipeline.
// Reset clears only the stage valid bits.
// Each stage holds while the next is full and stalled; empty stages still
// fill, so in_ready drops only when every stage is full and stalled.
// ----------------------------------------------------------------------------
module sensor_ring_cluster_finder_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [srcf_pkg::BITS_W-1:0]       sensor_bits,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [srcf_pkg::CNT_W-1:0]        cluster_count,
  output logic [srcf_pkg::IDX_W-1:0]        first_start,
  output logic [srcf_pkg::IDX_W-1:0]        first_end,
  output logic [srcf_pkg::IDX_W-1:0]        second_start,
  output logic [srcf_pkg::IDX_W-1:0]        second_end,
  output logic [srcf_pkg::IDX_W-1:0]        third_start,
  output logic [srcf_pkg::IDX_W-1:0]        third_end,
  output logic                              used_fill_in
);

  localparam int NSTG = srcf_pkg::RUN_SLOTS + 3;
  localparam int LAST = NSTG - 1;

  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] rdy;

  logic [srcf_pkg::MASK_W-1:0] ext_bits;
  srcf_pkg::ring_t             ring;

  srcf_pkg::track_t trk_orig [srcf_pkg::RUN_SLOTS+1];
  srcf_pkg::track_t trk_fill [srcf_pkg::RUN_SLOTS+1];
  srcf_pkg::track_t prep_orig;
  srcf_pkg::track_t prep_fill;
  srcf_pkg::track_t step_orig [srcf_pkg::RUN_SLOTS];
  srcf_pkg::track_t step_fill [srcf_pkg::RUN_SLOTS];
  srcf_pkg::res_t   res_next;
  srcf_pkg::res_t   res;

  // ready chain: a stage moves when it is empty or its beat moves on
  always_comb begin
    rdy[LAST] = !vld[LAST] || out_ready;
    for (int k = LAST - 1; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign in_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign ext_bits = srcf_pkg::MASK_W'(sensor_bits);

  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) begin
      ring <= ext_bits[srcf_pkg::SENSOR_COUNT-1:0];
    end
  end

  srcf_prep u_prep (
    .ring   (ring),
    .orig   (prep_orig),
    .filled (prep_fill)
  );

  always_ff @(posedge clk) begin
    if (rdy[1] && vld[0]) begin
      trk_orig[0] <= prep_orig;
      trk_fill[0] <= prep_fill;
    end
  end

  for (genvar g = 0; g < srcf_pkg::RUN_SLOTS; g++) begin : g_walk
    srcf_extract u_x_orig (
      .slot (srcf_pkg::SLOT_W'(g)),
      .din  (trk_orig[g]),
      .dout (step_orig[g])
    );
    srcf_extract u_x_fill (
      .slot (srcf_pkg::SLOT_W'(g)),
      .din  (trk_fill[g]),
      .dout (step_fill[g])
    );

    always_ff @(posedge clk) begin
      if (rdy[g+2] && vld[g+1]) begin
        trk_orig[g+1] <= step_orig[g];
        trk_fill[g+1] <= step_fill[g];
      end
    end
  end

  srcf_assemble u_asm (
    .orig   (trk_orig[srcf_pkg::RUN_SLOTS]),
    .filled (trk_fill[srcf_pkg::RUN_SLOTS]),
    .res    (res_next)
  );

  always_ff @(posedge clk) begin
    if (rdy[LAST] && vld[LAST-1]) begin
      res <= res_next;
    end
  end

  assign out_valid     = vld[LAST];
  assign cluster_count = res.count;
  assign first_start   = res.cstart[0];
  assign first_end     = res.cend[0];
  assign second_start  = res.cstart[1];
  assign second_end    = res.cend[1];
  assign third_start   = res.cstart[2];
  assign third_end     = res.cend[2];
  assign used_fill_in  = res.used;

`ifndef SYNTH
  a_empty_slots: assert property (@(posedge clk) disable iff (rst)
    out_valid && cluster_count == '0 |->
      first_start == srcf_pkg::SLOT_UNUSED && first_end == srcf_pkg::SLOT_UNUSED &&
      third_start == srcf_pkg::SLOT_UNUSED && third_end == srcf_pkg::SLOT_UNUSED)
    else $error("unused cluster slot not at sentinel");

  a_used_start: assert property (@(posedge clk) disable iff (rst)
    out_valid && cluster_count != '0 |-> first_start != srcf_pkg::SLOT_UNUSED)
    else $error("counted cluster has no start");

  a_full_block: assert property (@(posedge clk) disable iff (rst)
    (&vld) && !out_ready |-> !in_ready)
    else $error("input taken with every stage full and stalled");

  a_bubble_fill: assert property (@(posedge clk) disable iff (rst)
    vld[0] && !vld[1] |=> vld[1])
    else $error("beat did not advance into empty stage");
`endif

endmodule
